// ===== sv/tcspq_pkg.sv =====
// Shared types and codes for the three-class stable priority queue.
package tcspq_pkg;

  localparam int unsigned DefCapacity = 16;

  localparam int unsigned IdW     = 16;
  localparam int unsigned ClsW    = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned OccW    = 5;

  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  localparam logic [StatusW-1:0] STAT_ENQUEUED = 2'd0;
  localparam logic [StatusW-1:0] STAT_SERVED   = 2'd1;
  localparam logic [StatusW-1:0] STAT_EMPTY    = 2'd2;
  localparam logic [StatusW-1:0] STAT_FULL     = 2'd3;

  typedef struct packed {
    logic [IdW-1:0]  id;
    logic [ClsW-1:0] cls;
  } slot_t;

  // Broadcast from the control to every cell of the chain.
  typedef struct packed {
    logic  ins;
    logic  del;
    slot_t item;
  } cell_ctrl_t;

endpackage

// ===== sv/tcspq_if.sv =====
// Valid/ready channel interfaces for request and response transactions.
interface tcspq_in_if import tcspq_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            func;
  logic [IdW-1:0]  entry_id;
  logic [ClsW-1:0] entry_class;

  modport source (output valid, output func, output entry_id, output entry_class,
                  input ready);
  modport sink   (input valid, input func, input entry_id, input entry_class,
                  output ready);
endinterface

interface tcspq_out_if import tcspq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [IdW-1:0]     served_id;
  logic [ClsW-1:0]    served_class;
  logic [OccW-1:0]    occupancy;

  modport source (output valid, output status, output served_id, output served_class,
                  output occupancy, input ready);
  modport sink   (input valid, input status, input served_id, input served_class,
                  input occupancy, output ready);
endinterface

// ===== sv/three_class_stable_priority_queue_unit.sv =====
// Latency: the response is registered and valid the cycle after the request transaction.
// Throughput: one transaction per cycle unless the response is held by out_o.ready low;
// all cells of the chain update together from their neighbors on insert and head removal.
// The output register lets a new request enter while the last response is taken.
// Reset clears the entry count and the response valid; slot contents are not reset.
module three_class_stable_priority_queue_unit import tcspq_pkg::*; #(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tcspq_in_if.sink    in_i,
  tcspq_out_if.source out_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q;
  logic [StatusW-1:0] status_q, status_d;
  slot_t              served_q, served_d;

  logic       accept;
  logic       full, empty;
  cell_ctrl_t ctrl;
  logic [CAPACITY-1:0] occ;
  logic [CAPACITY-1:0] keep;
  slot_t               slots [CAPACITY];
  logic [CntW+OccW-1:0] occ_ext;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign full       = (count_q == CntW'(CAPACITY));
  assign empty      = (count_q == '0);

  assign ctrl.ins       = accept && (in_i.func == FUNC_ENQ) && !full;
  assign ctrl.del       = accept && (in_i.func == FUNC_DEQ) && !empty;
  assign ctrl.item.id   = in_i.entry_id;
  assign ctrl.item.cls  = in_i.entry_class;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    assign occ[g] = (CntW'(g) < count_q);
    tcspq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occ_i       (occ[g]),
      .left_keep_i ((g == 0) ? 1'b1 : keep[(g == 0) ? 0 : g - 1]),
      .left_i      (slots[(g == 0) ? 0 : g - 1]),
      .right_i     (slots[(g == CAPACITY - 1) ? g : g + 1]),
      .keep_o      (keep[g]),
      .slot_o      (slots[g])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = status_q;
    served_d = served_q;
    if (accept) begin
      served_d = '0;
      if (in_i.func == FUNC_ENQ) begin
        if (full) begin
          status_d = STAT_FULL;
        end else begin
          status_d = STAT_ENQUEUED;
          count_d  = count_q + CntW'(1);
        end
      end else begin
        if (empty) begin
          status_d = STAT_EMPTY;
        end else begin
          status_d = STAT_SERVED;
          served_d = slots[0];
          count_d  = count_q - CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    served_q <= served_d;
  end

  // count_q already holds the post-transaction count while the response waits.
  assign occ_ext = {{OccW{1'b0}}, count_q};

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = status_q;
  assign out_o.served_id    = served_q.id;
  assign out_o.served_class = served_q.cls;
  assign out_o.occupancy    = occ_ext[OccW-1:0];

endmodule

// ===== sv/tcspq_cell.sv =====
// One slot of the sorted chain: holds, takes the new item, or shifts from a neighbor.
module tcspq_cell import tcspq_pkg::*; (
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  logic       occ_i,
  input  logic       left_keep_i,
  input  slot_t      left_i,
  input  slot_t      right_i,
  output logic       keep_o,
  output slot_t      slot_o
);

  slot_t slot_q;
  slot_t slot_d;

  // Entry stays put on insert when it ranks equal or ahead of the new item.
  assign keep_o = occ_i && (slot_q.cls <= ctrl_i.item.cls);

  always_comb begin
    slot_d = slot_q;
    if (ctrl_i.ins) begin
      if (keep_o) begin
        slot_d = slot_q;
      end else if (left_keep_i) begin
        slot_d = ctrl_i.item;
      end else begin
        slot_d = left_i;
      end
    end else if (ctrl_i.del) begin
      slot_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign slot_o = slot_q;

endmodule

// ===== sim/three_class_stable_priority_queue_unit_tb.sv =====
// Self-checking testbench for the three-class stable priority queue unit.
module three_class_stable_priority_queue_unit_tb import tcspq_pkg::*; ();

  localparam int unsigned Cap         = DefCapacity;
  localparam int unsigned QuietLimit  = 1000;
  localparam int unsigned RandomItems = 1600;
  localparam int unsigned DrainCycles = 10;

  typedef struct {
    logic            func;
    logic [IdW-1:0]  id;
    logic [ClsW-1:0] cls;
    int unsigned     hold_after;  // idle cycles on the request side after this one
  } req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [IdW-1:0]     id;
    logic [ClsW-1:0]    cls;
    logic [OccW-1:0]    occ;
  } resp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b1;

  tcspq_in_if  in_ch ();
  tcspq_out_if out_ch ();

  three_class_stable_priority_queue_unit #(
    .CAPACITY(Cap)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  req_t        req_backlog[$];
  resp_t       expected_resp[$];
  int unsigned mismatch_count = 0;

  // Shadow of the queue contents, head at index 0.
  slot_t       shadow_slots[Cap];
  int unsigned shadow_count = 0;

  function automatic resp_t apply_request(logic func, logic [IdW-1:0] id,
                                          logic [ClsW-1:0] cls);
    resp_t       r;
    int unsigned pos;
    r = '0;
    if (func == FUNC_ENQ) begin
      if (shadow_count >= Cap) begin
        r.status = STAT_FULL;
      end else begin
        // new entry goes behind everything of equal or better class
        pos = 0;
        while (pos < shadow_count && shadow_slots[pos].cls <= cls) pos++;
        for (int i = shadow_count; i > pos; i--) shadow_slots[i] = shadow_slots[i-1];
        shadow_slots[pos].id  = id;
        shadow_slots[pos].cls = cls;
        shadow_count++;
        r.status = STAT_ENQUEUED;
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = STAT_EMPTY;
      end else begin
        r.id  = shadow_slots[0].id;
        r.cls = shadow_slots[0].cls;
        for (int i = 1; i < shadow_count; i++) shadow_slots[i-1] = shadow_slots[i];
        shadow_count--;
        r.status = STAT_SERVED;
      end
    end
    r.occ = OccW'(shadow_count);
    return r;
  endfunction

  task automatic add_req(logic func, logic [IdW-1:0] id, logic [ClsW-1:0] cls,
                         int unsigned hold_after);
    req_t r;
    r.func       = func;
    r.id         = id;
    r.cls        = cls;
    r.hold_after = hold_after;
    req_backlog.push_back(r);
  endtask

  // Request driver: prediction happens at the accepting edge.
  req_t        next_req;
  int unsigned gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid       <= 1'b0;
      in_ch.func        <= FUNC_ENQ;
      in_ch.entry_id    <= '0;
      in_ch.entry_class <= '0;
      gap_left          <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_resp.push_back(apply_request(in_ch.func, in_ch.entry_id, in_ch.entry_class));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left != 0 || req_backlog.size() == 0) begin
          in_ch.valid <= 1'b0;
          if (gap_left != 0) gap_left <= gap_left - 1;
        end else begin
          next_req          = req_backlog.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.func        <= next_req.func;
          in_ch.entry_id    <= next_req.id;
          in_ch.entry_class <= next_req.cls;
          gap_left          <= next_req.hold_after;
        end
      end
    end
  end

  // Response monitor with random back-pressure.
  resp_t       got_resp;
  resp_t       want_resp;
  int unsigned stall_left;
  logic        sink_stalls;
  int unsigned stall_draw;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
      sink_stalls  <= 1'b1;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got_resp = '{status: out_ch.status, id: out_ch.served_id,
                     cls: out_ch.served_class, occ: out_ch.occupancy};
        if (expected_resp.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected response: status=%0d id=%h class=%0d occ=%0d",
                   $time, got_resp.status, got_resp.id, got_resp.cls, got_resp.occ);
        end else begin
          want_resp = expected_resp.pop_front();
          if (got_resp !== want_resp) begin
            mismatch_count++;
            $display("%0t: exp st=%0d id=%h cls=%0d occ=%0d got st=%0d id=%h cls=%0d occ=%0d",
                     $time, want_resp.status, want_resp.id, want_resp.cls, want_resp.occ,
                     got_resp.status, got_resp.id, got_resp.cls, got_resp.occ);
          end
        end
        if ($urandom_range(0, 63) == 0) sink_stalls <= !sink_stalls;
        stall_draw = sink_stalls ? $urandom_range(0, 7) : 0;
        out_ch.ready <= (stall_draw == 0);
        stall_left   <= stall_draw;
      end else if (stall_left != 0) begin
        stall_left   <= stall_left - 1;
        out_ch.ready <= (stall_left == 1);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transaction.
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: watchdog expired with %0d responses outstanding",
                 $time, expected_resp.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  int unsigned made;
  int unsigned seg_len;
  int unsigned enq_pct;
  logic        src_idles;
  logic [ClsW-1:0] pick_cls;

  initial begin
    // Directed: dequeue on empty, fill with all classes and id extremes,
    // drop on full, then drain a few to see class order and FIFO within a class.
    add_req(FUNC_DEQ, 16'hFFFF, 2'd3, $urandom_range(0, 7));
    add_req(FUNC_ENQ, 16'hFFFF, 2'd2, $urandom_range(0, 7));
    add_req(FUNC_ENQ, 16'h0000, 2'd2, $urandom_range(0, 7));
    add_req(FUNC_ENQ, 16'h1111, 2'd1, $urandom_range(0, 7));
    add_req(FUNC_ENQ, 16'h2222, 2'd3, $urandom_range(0, 7));
    add_req(FUNC_ENQ, 16'h3333, 2'd0, $urandom_range(0, 7));
    add_req(FUNC_ENQ, 16'h4444, 2'd1, $urandom_range(0, 7));
    add_req(FUNC_ENQ, 16'h0000, 2'd0, $urandom_range(0, 7));
    add_req(FUNC_ENQ, 16'hFFFF, 2'd0, $urandom_range(0, 7));
    add_req(FUNC_ENQ, 16'h5555, 2'd3, $urandom_range(0, 7));
    add_req(FUNC_ENQ, 16'hAAAA, 2'd2, $urandom_range(0, 7));
    add_req(FUNC_ENQ, 16'h6666, 2'd1, $urandom_range(0, 7));
    add_req(FUNC_ENQ, 16'h7777, 2'd0, $urandom_range(0, 7));
    add_req(FUNC_ENQ, 16'h8888, 2'd2, $urandom_range(0, 7));
    add_req(FUNC_ENQ, 16'h9999, 2'd1, $urandom_range(0, 7));
    add_req(FUNC_ENQ, 16'hBBBB, 2'd3, $urandom_range(0, 7));
    add_req(FUNC_ENQ, 16'hCCCC, 2'd0, $urandom_range(0, 7));
    add_req(FUNC_ENQ, 16'hDDDD, 2'd0, $urandom_range(0, 7));
    add_req(FUNC_DEQ, 16'h0000, 2'd0, $urandom_range(0, 7));
    add_req(FUNC_DEQ, 16'hFFFF, 2'd2, $urandom_range(0, 7));
    add_req(FUNC_DEQ, 16'h0000, 2'd1, $urandom_range(0, 7));
    add_req(FUNC_DEQ, 16'h1234, 2'd0, $urandom_range(0, 7));

    // Random: segments biased toward filling, draining or mixed traffic.
    made = 0;
    while (made < RandomItems) begin
      seg_len   = $urandom_range(10, 60);
      case ($urandom_range(0, 2))
        0: enq_pct = 15;
        1: enq_pct = 50;
        default: enq_pct = 85;
      endcase
      src_idles = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < seg_len; k++) begin
        pick_cls = ($urandom_range(0, 15) == 0) ? 2'd3 : ClsW'($urandom_range(0, 2));
        add_req(($urandom_range(0, 99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ,
                IdW'($urandom), pick_cls, src_idles ? $urandom_range(0, 7) : 0);
      end
      made += seg_len;
    end

    rst_ni <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (req_backlog.size() != 0 || in_ch.valid || expected_resp.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0 && expected_resp.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
